// ===== src/itrk_pkg.sv =====
`timescale 1ns / 1ps
package itrk_pkg;

  localparam int STATE_FRAC_BITS   = 16;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int CF = 24;   // coefficient fraction bits
  localparam int DW = 48;   // filter datapath width
  localparam int AW = 28;   // CORDIC datapath width

  localparam logic signed [29:0] K_DT   = 30'sd335544;
  localparam logic signed [29:0] K_DT2H = 30'sd3355;
  localparam logic signed [29:0] K_G    = 30'sd164584489;
  localparam logic signed [29:0] K_H    = 30'sd5872026;
  localparam logic signed [17:0] K_GYRO = 18'sd118591;
  localparam logic signed [AW-1:0] K_HALF_PI = AW'(26353589);

  localparam logic [0:0] REG_GAIN_MODE    = 1'b0;
  localparam logic [0:0] REG_CALIB_FRAMES = 1'b1;

  // filter sequence steps; steps from OP_CORR on alternate gain columns
  localparam logic [3:0] OP_GX0  = 4'd0;
  localparam logic [3:0] OP_HX2  = 4'd1;
  localparam logic [3:0] OP_P0A  = 4'd2;
  localparam logic [3:0] OP_P0B  = 4'd3;
  localparam logic [3:0] OP_P1   = 4'd4;
  localparam logic [3:0] OP_CORR = 4'd5;
  localparam logic [3:0] OP_LAST = 4'd12;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] tilt_angle;
    logic signed [15:0] roll_rate;
    logic signed [15:0] tilt_rate;
    logic               filter_active;
  } result_t;

  typedef struct packed {
    logic               start;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } cord_req_t;

  typedef struct packed {
    logic                done;
    logic signed [AW-1:0] ang;
  } cord_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CROLL, ST_CTILT, ST_UPDATE, ST_DIVLD, ST_DIV, ST_PREP, ST_MUL, ST_EMIT
  } state_t;

  function automatic logic signed [AW-1:0] atan_q24(input logic [4:0] idx);
    case (idx)
      5'd0:  return AW'(13176795);
      5'd1:  return AW'(7778716);
      5'd2:  return AW'(4110060);
      5'd3:  return AW'(2086331);
      5'd4:  return AW'(1047214);
      5'd5:  return AW'(524117);
      5'd6:  return AW'(262123);
      5'd7:  return AW'(131069);
      5'd8:  return AW'(65536);
      5'd9:  return AW'(32768);
      5'd10: return AW'(16384);
      5'd11: return AW'(8192);
      5'd12: return AW'(4096);
      5'd13: return AW'(2048);
      5'd14: return AW'(1024);
      5'd15: return AW'(512);
      5'd16: return AW'(256);
      5'd17: return AW'(128);
      5'd18: return AW'(64);
      5'd19: return AW'(32);
      5'd20: return AW'(16);
      5'd21: return AW'(8);
      5'd22: return AW'(4);
      5'd23: return AW'(2);
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [29:0] gain(input logic mode, input logic [2:0] k);
    case ({mode, k})
      4'h0: return 30'sd11426;
      4'h1: return 30'sd137410;
      4'h2: return 30'sd8317;
      4'h3: return 30'sd990485;
      4'h4: return 30'sd18807;
      4'h5: return 30'sd3085256;
      4'h6: return -30'sd1661;
      4'h7: return 30'sd3738;
      4'h8: return 30'sd37058;
      4'h9: return 30'sd241151;
      4'hA: return 30'sd28688;
      4'hB: return 30'sd1909632;
      4'hC: return 30'sd38653;
      4'hD: return 30'sd5969380;
      4'hE: return -30'sd16475;
      4'hF: return 30'sd39587;
      default: return '0;
    endcase
  endfunction

  // fixed point rescale, rounding half up when bits are dropped
  function automatic logic signed [63:0] resc(input logic signed [63:0] v,
                                              input int from, input int to);
    if (to >= from) return v <<< (to - from);
    else return (v + (64'sd1 <<< (from - to - 1))) >>> (from - to);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    else if (v < -64'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // Q.24 angle to Q2.13, optionally negated
  function automatic logic signed [15:0] raw_q13(input logic signed [AW-1:0] ang,
                                                 input logic negate);
    logic signed [63:0] v;
    v = 64'(ang);
    if (negate) v = -v;
    return sat16((v + 64'sd1024) >>> 11);
  endfunction

endpackage

// ===== src/itrk_front.sv =====
`timescale 1ns / 1ps
module itrk_front import itrk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  sample_t sample,
  input  logic    q_pop,
  output logic    q_empty,
  output sample_t head
);

  sample_t    slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       wr;
  logic       rd;

  assign full    = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign head    = slots[rptr];
  assign wr      = push && !full;
  assign rd      = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= !wptr;
      end
      if (rd) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== src/itrk_cordic.sv =====
`timescale 1ns / 1ps
module itrk_cordic import itrk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cord_req_t req,
  output cord_rsp_t rsp
);

  localparam int ITER = CORDIC_ITERATIONS;
  localparam int IW   = $clog2(ITER);

  logic                 busy;
  logic                 done;
  logic                 zero;
  logic [IW-1:0]        i;
  logic signed [AW-1:0] cx;
  logic signed [AW-1:0] cy;
  logic signed [AW-1:0] cang;
  logic signed [AW-1:0] x0;
  logic signed [AW-1:0] y0;
  logic signed [AW-1:0] dx;
  logic signed [AW-1:0] dy;

  assign x0 = AW'(req.x) <<< 8;
  assign y0 = AW'(req.y) <<< 8;
  assign dx = cy >>> i;
  assign dy = cx >>> i;

  assign rsp.done = done;
  assign rsp.ang  = zero ? '0 : cang;

  always_ff @(posedge clk) begin
    if (req.start) begin
      zero <= (req.x == 16'sd0) && (req.y == 16'sd0);
      if (x0 < 0) begin
        if (y0 >= 0) begin
          cx <= y0;  cy <= -x0; cang <= K_HALF_PI;
        end else begin
          cx <= -y0; cy <= x0;  cang <= -K_HALF_PI;
        end
      end else begin
        cx <= x0; cy <= y0; cang <= '0;
      end
      i <= '0;
    end else if (busy) begin
      if (cy > 0) begin
        cx <= cx + dx; cy <= cy - dy; cang <= cang + atan_q24(5'(i));
      end else begin
        cx <= cx - dx; cy <= cy + dy; cang <= cang - atan_q24(5'(i));
      end
      i <= i + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && i == IW'(ITER - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== src/itrk_back.sv =====
`timescale 1ns / 1ps
module itrk_back import itrk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  sample_t    head,
  input  logic       q_empty,
  output logic       q_pop,
  output cord_req_t  cord_req,
  input  cord_rsp_t  cord_rsp,
  input  logic       gain_mode,
  input  logic [7:0] calib_frames,
  output result_t    result,
  output logic       empty,
  input  logic       pop
);

  state_t state, state_next;

  sample_t            item;
  logic signed [15:0] raw_roll;
  logic signed [15:0] raw_tilt;
  logic [7:0]         frame_count;
  logic signed [23:0] gyro_sum [2];
  logic signed [15:0] gyro_offset [2];
  logic signed [31:0] est [2][4];
  logic               running;
  logic signed [15:0] last_rates [2];
  logic               axis;
  logic [3:0]         op;
  logic               phase;
  logic signed [71:0] acc;
  logic signed [DW-1:0] c0, c1, p0, p1, r, s0, s1;
  logic               div_axis;
  logic [4:0]         div_cnt;
  logic [23:0]        num;
  logic [7:0]         rem;
  logic               neg;
  logic               out_valid;
  result_t            out_data;

  logic [7:0]           fc_new;
  logic signed [23:0]   sum_new [2];
  logic signed [31:0]   x0, x1, x2, x3;
  logic signed [DW-1:0] mul_a;
  logic signed [29:0]   mul_c;
  logic signed [50:0]   lo_prod;
  logic signed [57:0]   hi_prod;
  logic signed [71:0]   mul_sum;
  logic signed [DW-1:0] m;
  logic [1:0]           kk;
  logic signed [DW-1:0] p_sel;
  logic [8:0]           rem_sh;
  logic                 ge;
  logic [23:0]          q_final;
  logic signed [63:0]   qv;
  logic signed [16:0]   diff;
  logic signed [34:0]   gprod;
  logic signed [23:0]   sum_sel;

  assign fc_new     = (frame_count == 8'hFF) ? frame_count : frame_count + 8'd1;
  assign sum_new[0] = gyro_sum[0] + 24'(item.gyro_x);
  assign sum_new[1] = gyro_sum[1] + 24'(item.gyro_y);
  assign x0 = est[axis][0];
  assign x1 = est[axis][1];
  assign x2 = est[axis][2];
  assign x3 = est[axis][3];

  // operand select for the shared two-pass multiplier
  always_comb begin
    case (op)
      OP_GX0: begin mul_a = DW'(x0); mul_c = K_G;    end
      OP_HX2: begin mul_a = DW'(x2); mul_c = K_H;    end
      OP_P0A: begin mul_a = DW'(x1); mul_c = K_DT;   end
      OP_P0B: begin mul_a = DW'(x2); mul_c = K_DT2H; end
      OP_P1:  begin mul_a = DW'(x2); mul_c = K_DT;   end
      default: begin
        mul_a = op[0] ? c0 : c1;
        mul_c = gain(gain_mode, 3'(op - OP_CORR));
      end
    endcase
  end

  assign lo_prod = $signed({1'b0, mul_a[19:0]}) * mul_c;
  assign hi_prod = $signed(mul_a[DW-1:20]) * mul_c;
  assign mul_sum = acc + (72'(hi_prod) <<< 20) + (72'sd1 <<< (CF - 1));
  assign m       = $signed(mul_sum[71:CF]);

  assign kk = 2'((op - OP_CORR) >> 1);
  always_comb begin
    case (kk)
      2'd0:    p_sel = p0;
      2'd1:    p_sel = p1;
      2'd2:    p_sel = DW'(x2);
      default: p_sel = DW'(x3);
    endcase
  end

  // restoring divide step for the gyro mean
  assign rem_sh  = {rem, num[23]};
  assign ge      = rem_sh >= {1'b0, frame_count};
  assign q_final = {num[22:0], ge};
  assign qv      = neg ? -$signed({40'd0, q_final}) : $signed({40'd0, q_final});
  assign sum_sel = gyro_sum[div_axis];

  assign diff  = (axis ? 17'(item.gyro_y) : 17'(item.gyro_x)) - 17'(gyro_offset[axis]);
  assign gprod = diff * K_GYRO;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (!q_empty && !out_valid) state_next = ST_CROLL;
      ST_CROLL:  if (cord_rsp.done) state_next = ST_CTILT;
      ST_CTILT:  if (cord_rsp.done) state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (running) state_next = ST_PREP;
        else if (fc_new >= calib_frames) state_next = ST_DIVLD;
        else state_next = ST_IDLE;
      end
      ST_DIVLD:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == 5'd23) state_next = div_axis ? ST_PREP : ST_DIVLD;
      end
      ST_PREP:   state_next = ST_MUL;
      ST_MUL: begin
        if (phase && op == OP_LAST) state_next = axis ? ST_EMIT : ST_PREP;
      end
      ST_EMIT:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop          = (state == ST_IDLE) && !q_empty && !out_valid;
    cord_req.start = q_pop || (state == ST_CROLL && cord_rsp.done);
    cord_req.y     = (state == ST_IDLE) ? head.accel_y : item.accel_x;
    cord_req.x     = (state == ST_IDLE) ? head.accel_z : item.accel_z;
  end

  assign empty  = !out_valid;
  assign result = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= 8'd0;
      running     <= 1'b0;
      out_valid   <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        gyro_sum[a]    <= '0;
        gyro_offset[a] <= '0;
        last_rates[a]  <= '0;
        for (int k = 0; k < 4; k++) begin
          est[a][k] <= '0;
        end
      end
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) item <= head;
        end
        ST_CROLL: begin
          if (cord_rsp.done) raw_roll <= raw_q13(cord_rsp.ang, 1'b0);
        end
        ST_CTILT: begin
          if (cord_rsp.done) raw_tilt <= raw_q13(cord_rsp.ang, 1'b1);
        end
        ST_UPDATE: begin
          frame_count <= fc_new;
          axis        <= 1'b0;
          div_axis    <= 1'b0;
          if (!running) begin
            gyro_sum[0] <= sum_new[0];
            gyro_sum[1] <= sum_new[1];
            if (fc_new < calib_frames) begin
              out_valid <= 1'b1;
              out_data  <= '{roll_angle: raw_roll, tilt_angle: raw_tilt,
                             roll_rate: last_rates[0], tilt_rate: last_rates[1],
                             filter_active: 1'b0};
            end
          end
        end
        ST_DIVLD: begin
          neg     <= sum_sel < 0;
          num     <= (sum_sel < 0 ? 24'(-sum_sel) : 24'(sum_sel)) + 24'(frame_count >> 1);
          rem     <= 8'd0;
          div_cnt <= 5'd0;
        end
        ST_DIV: begin
          rem     <= ge ? 8'(rem_sh - {1'b0, frame_count}) : rem_sh[7:0];
          num     <= q_final;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd23) begin
            gyro_offset[div_axis] <= sat16(qv);
            div_axis <= 1'b1;
            if (div_axis) begin
              running <= 1'b1;
              for (int a = 0; a < 2; a++) begin
                for (int k = 1; k < 4; k++) begin
                  est[a][k] <= '0;
                end
              end
              est[0][0] <= 32'(resc(64'(raw_roll), 13, STATE_FRAC_BITS));
              est[1][0] <= 32'(resc(64'(raw_tilt), 13, STATE_FRAC_BITS));
            end
          end
        end
        ST_PREP: begin
          s0 <= axis ? DW'(resc(-64'(item.accel_x), 8, STATE_FRAC_BITS))
                     : DW'(resc(64'(item.accel_y), 8, STATE_FRAC_BITS));
          s1 <= DW'(resc(64'(gprod), CF, STATE_FRAC_BITS));
          op    <= OP_GX0;
          phase <= 1'b0;
        end
        ST_MUL: begin
          if (!phase) begin
            acc <= 72'(lo_prod);
            if (op == OP_GX0) c1 <= DW'(x1) + DW'(x3) - s1;
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            case (op)
              OP_GX0: c0 <= m;
              OP_HX2: c0 <= c0 + m - s0;
              OP_P0A: p0 <= DW'(x0) + m;
              OP_P0B: p0 <= p0 + m;
              OP_P1:  p1 <= DW'(x1) + m;
              default: begin
                if (op[0]) r <= p_sel - m;
                else est[axis][kk] <= sat32(64'(r - m));
              end
            endcase
            if (op == OP_LAST) begin
              axis <= 1'b1;
            end else begin
              op <= op + 4'd1;
            end
          end
        end
        ST_EMIT: begin
          last_rates[0] <= sat16(resc(64'(est[0][1]), STATE_FRAC_BITS, 10));
          last_rates[1] <= sat16(resc(64'(est[1][1]), STATE_FRAC_BITS, 10));
          out_valid     <= 1'b1;
          out_data      <= '{
            roll_angle: sat16(resc(64'(est[0][0]), STATE_FRAC_BITS, 13)),
            tilt_angle: sat16(resc(64'(est[1][0]), STATE_FRAC_BITS, 13)),
            roll_rate:  sat16(resc(64'(est[0][1]), STATE_FRAC_BITS, 10)),
            tilt_rate:  sat16(resc(64'(est[1][1]), STATE_FRAC_BITS, 10)),
            filter_active: 1'b1};
        end
        default: ;
      endcase
    end
  end

  a_running_sticks: assert property (@(posedge clk) disable iff (rst)
    running |=> running)
    else $error("filter dropped out of running");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (frame_count != 8'd0) |=> (frame_count >= $past(frame_count)))
    else $error("frame counter went backwards");

  a_active_needs_running: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.filter_active) |-> running)
    else $error("filtered result before calibration");

  a_cordic_done_expected: assert property (@(posedge clk) disable iff (rst)
    cord_rsp.done |-> (state == ST_CROLL || state == ST_CTILT))
    else $error("unexpected CORDIC completion");

endmodule

// ===== src/imu_tilt_roll_kalman_filter.sv =====
`timescale 1ns / 1ps
// IMU roll/tilt estimator with a steady-state Kalman filter per axis.
// Samples enter through push/full (accepted when push && !full) into a
// two-entry queue; results leave through empty/pop, the oldest result on
// result while empty is low. One result per sample.
// The first calib_frames-1 samples return raw atan2 angles while the gyro
// readings are summed; the frame that reaches the count sets the gyro
// offsets, seeds the state and turns the filter on (filter_active = 1).
// Work per sample falls to the shared iterative CORDIC (two atan2) and the
// shared two-pass multiplier (13 products per axis), and on the frame that
// ends calibration also to the restoring divider. One sample is worked at
// a time.
// The back end starts a sample only when the result register is free, so a
// stalled receiver holds one result, the queue fills, then full rises.
// cfg_wen writes gain_mode (index 0) or calib_frames (index 1); write
// only while idle. Reset (rst, synchronous) clears the control and filter
// state and the queues, sets gain_mode to 0 and calib_frames to 30.
module imu_tilt_roll_kalman_filter import itrk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  sample_t    sample,
  output logic       empty,
  input  logic       pop,
  output result_t    result,
  input  logic       cfg_wen,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic       gain_mode;
  logic [7:0] calib_frames;
  logic       q_pop;
  logic       q_empty;
  sample_t    head;
  cord_req_t  cord_req;
  cord_rsp_t  cord_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_mode    <= 1'b0;
      calib_frames <= 8'd30;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_GAIN_MODE:    gain_mode    <= cfg_data[0];
        REG_CALIB_FRAMES: calib_frames <= cfg_data;
        default: ;
      endcase
    end
  end

  itrk_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .sample  (sample),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .head    (head)
  );

  itrk_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cord_req),
    .rsp (cord_rsp)
  );

  itrk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .cord_req     (cord_req),
    .cord_rsp     (cord_rsp),
    .gain_mode    (gain_mode),
    .calib_frames (calib_frames),
    .result       (result),
    .empty        (empty),
    .pop          (pop)
  );

endmodule
